### design/vcsg_pkg.sv
// Shared types and constants for the voice capture silence gate.
// Depends on nothing; every other design file refers to it by scoped name.
package vcsg_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_THRESHOLD   = 2'd0;
    localparam logic [1:0] REG_MAX_SILENT  = 2'd1;
    localparam logic [1:0] REG_POST_DELAY  = 2'd2;
    localparam logic [1:0] REG_HERALD      = 2'd3;

    // Result action codes
    localparam logic [2:0] ACT_DROP       = 3'd0;
    localparam logic [2:0] ACT_STORE      = 3'd1;
    localparam logic [2:0] ACT_SEND_STORE = 3'd2;
    localparam logic [2:0] ACT_SEND_FIRST = 3'd3;
    localparam logic [2:0] ACT_SEND_CUR   = 3'd4;

    // Field widths
    localparam int THR_W    = 9;
    localparam int TICKS_W  = 16;
    localparam int HTICKS_W = 10;
    localparam int TIME_W   = 32;
    localparam int LEN_W    = 16;
    localparam int FILL_W   = 14;
    localparam int ACT_W    = 3;

    // Offset-binary mid level and full-scale threshold
    localparam logic [7:0]       MID_LEVEL = 8'd128;
    localparam logic [THR_W-1:0] THR_FULL  = 9'd256;

    // 11025 samples/s over 60 ticks/s is exactly 735/4 samples per tick
    localparam int HERALD_MUL   = 735;
    localparam int HERALD_SHIFT = 2;
    localparam int HPROD_W      = 20;
    localparam int HERALD_W     = HPROD_W - HERALD_SHIFT;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef enum logic [2:0] {
        PH_SILENCE = 3'b001,
        PH_COLLECT = 3'b010,
        PH_STREAM  = 3'b100
    } gate_phase_t;

    // One finished capture buffer, as classified by the front
    typedef struct packed {
        logic              noisy;
        logic [LEN_W-1:0]  len;
        logic [TIME_W-1:0] tick;
    } buf_summary_t;

    // Timing registers used by the back
    typedef struct packed {
        logic [TICKS_W-1:0]  max_silent;
        logic [TICKS_W-1:0]  post_delay;
        logic [HTICKS_W-1:0] herald_ticks;
    } gate_cfg_t;

endpackage

### design/vcsg_front.sv
// Front part: accumulates per-buffer deviation statistics and classifies each
// finished buffer as noisy or quiet. Depends on vcsg_pkg.
module vcsg_front #(
    parameter int SUBSAMPLE_STEP = 16,
    parameter int READ_LIMIT     = 50000
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_accept,
    input  logic [7:0]                        sample,
    input  logic                              last_of_buffer,
    input  logic [vcsg_pkg::TIME_W-1:0]       tick,
    input  logic [vcsg_pkg::THR_W-1:0]        threshold,
    input  logic                              q_full,
    output logic                              hold_input,
    output logic                              q_push,
    output vcsg_pkg::buf_summary_t            q_data
);

    localparam int CNT_W = $clog2(READ_LIMIT / SUBSAMPLE_STEP + 2);
    localparam int SUM_W = CNT_W + 7;
    localparam int PH_W  = (SUBSAMPLE_STEP > 1) ? $clog2(SUBSAMPLE_STEP) : 1;
    localparam int CMP_W = CNT_W + vcsg_pkg::THR_W;
    localparam logic [PH_W-1:0] PH_LAST = PH_W'(SUBSAMPLE_STEP - 1);
    localparam logic [vcsg_pkg::LEN_W-1:0] LEN_LIMIT = vcsg_pkg::LEN_W'(READ_LIMIT);

    logic [SUM_W-1:0]             sum_reg, sum_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [PH_W-1:0]              phase_reg, phase_next;
    logic [vcsg_pkg::LEN_W-1:0]   len_reg, len_next;

    logic                         end_valid_reg;
    logic [SUM_W-1:0]             end_sum_reg;
    logic [CNT_W-1:0]             end_cnt_reg;
    logic [vcsg_pkg::LEN_W-1:0]   end_len_reg;
    logic [vcsg_pkg::TIME_W-1:0]  end_tick_reg;

    logic [7:0]                   deviation;
    logic [vcsg_pkg::THR_W-1:0]   thr_clamped;
    logic [CMP_W-1:0]             thr_term;
    logic [CMP_W-1:0]             dev_term;

    // Absolute deviation from the mid level
    assign deviation = (sample >= vcsg_pkg::MID_LEVEL) ? (sample - vcsg_pkg::MID_LEVEL)
                                                       : (vcsg_pkg::MID_LEVEL - sample);

    // Accumulate one sample; samples past the read limit are ignored
    always_comb
    begin
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        len_next   = len_reg;
        if (len_reg < LEN_LIMIT)
        begin
            if (phase_reg == '0)
            begin
                sum_next = sum_reg + SUM_W'(deviation);
                cnt_next = cnt_reg + 1'b1;
            end
            phase_next = (phase_reg == PH_LAST) ? '0 : phase_reg + 1'b1;
            len_next   = len_reg + 1'b1;
        end
    end

    // Hold new input while a finished buffer cannot enter the queue
    assign hold_input = end_valid_reg && q_full;
    assign q_push     = end_valid_reg && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            cnt_reg       <= '0;
            phase_reg     <= '0;
            len_reg       <= '0;
            end_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                if (last_of_buffer)
                begin
                    sum_reg   <= '0;
                    cnt_reg   <= '0;
                    phase_reg <= '0;
                    len_reg   <= '0;
                end
                else
                begin
                    sum_reg   <= sum_next;
                    cnt_reg   <= cnt_next;
                    phase_reg <= phase_next;
                    len_reg   <= len_next;
                end
            end
            if (in_accept && last_of_buffer)
                end_valid_reg <= 1'b1;
            else if (q_push)
                end_valid_reg <= 1'b0;
        end
    end

    // Capture the totals of a finished buffer
    always_ff @(posedge clk)
    begin
        if (in_accept && last_of_buffer)
        begin
            end_sum_reg  <= sum_next;
            end_cnt_reg  <= cnt_next;
            end_len_reg  <= len_next;
            end_tick_reg <= tick;
        end
    end

    // Judge noise: 2*sum > threshold*count, threshold clamped to full scale
    assign thr_clamped = (threshold > vcsg_pkg::THR_FULL) ? vcsg_pkg::THR_FULL : threshold;
    assign thr_term    = CMP_W'(thr_clamped) * CMP_W'(end_cnt_reg);
    assign dev_term    = CMP_W'({end_sum_reg, 1'b0});

    assign q_data.noisy = dev_term > thr_term;
    assign q_data.len   = end_len_reg;
    assign q_data.tick  = end_tick_reg;

endmodule

### design/vcsg_fifo.sv
// Short queue of classified buffers between the front and the back.
// Depends on vcsg_pkg for the entry type and depth.
module vcsg_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  vcsg_pkg::buf_summary_t push_data,
    input  logic                   pop,
    output logic                   full,
    output logic                   empty,
    output vcsg_pkg::buf_summary_t head
);

    localparam int CNT_W = vcsg_pkg::QPTR_W + 1;

    vcsg_pkg::buf_summary_t         mem_reg [vcsg_pkg::QUEUE_DEPTH];
    logic [vcsg_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [vcsg_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]               count_reg;

    assign full  = (count_reg == CNT_W'(vcsg_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Write the incoming entry
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

### design/vcsg_back.sv
// Back part: runs the gate, herald and store decisions for each classified
// buffer and holds the result in an output register. Depends on vcsg_pkg.
module vcsg_back #(
    parameter int STORE_LIMIT = 11017,
    parameter int READ_LIMIT  = 50000
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  vcsg_pkg::gate_cfg_t                 cfg,
    input  logic                                q_empty,
    input  vcsg_pkg::buf_summary_t              q_head,
    output logic                                q_pop,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [vcsg_pkg::ACT_W-1:0]          action,
    output logic                                noisy,
    output logic [vcsg_pkg::LEN_W-1:0]          herald_samples,
    output logic [vcsg_pkg::LEN_W-1:0]          send_length,
    output logic [vcsg_pkg::FILL_W-1:0]         buffered_bytes
);

    localparam int TW = vcsg_pkg::TIME_W + 1;
    localparam int HSUM_W = vcsg_pkg::HERALD_W + 1;
    localparam logic [vcsg_pkg::FILL_W-1:0] FILL_LIMIT = vcsg_pkg::FILL_W'(STORE_LIMIT);
    localparam logic [HSUM_W-1:0] HSUM_LIMIT = HSUM_W'(READ_LIMIT);

    vcsg_pkg::gate_phase_t              phase_reg, phase_next, work_phase;
    logic [vcsg_pkg::TIME_W-1:0]        last_noise_reg, last_noise_next;
    logic [vcsg_pkg::TIME_W-1:0]        first_noise_reg, first_noise_next, work_first;
    logic [vcsg_pkg::FILL_W-1:0]        fill_reg, fill_next;
    logic [vcsg_pkg::HERALD_W-1:0]      herald_len_reg;
    logic [vcsg_pkg::HPROD_W-1:0]       herald_prod;

    logic                               out_valid_reg;
    logic [vcsg_pkg::ACT_W-1:0]         action_reg, action_next;
    logic                               noisy_reg;
    logic [vcsg_pkg::LEN_W-1:0]         herald_reg, herald_next;
    logic [vcsg_pkg::LEN_W-1:0]         send_reg, send_next;
    logic [vcsg_pkg::FILL_W-1:0]        reported_reg, reported_next;

    logic                               hangover_done;
    logic                               delay_done;
    logic                               herald_fits;
    logic [vcsg_pkg::FILL_W-1:0]        held;
    logic [vcsg_pkg::FILL_W-1:0]        room;

    // Herald length in samples, refreshed from the register every cycle
    assign herald_prod = vcsg_pkg::HPROD_W'(cfg.herald_ticks)
                       * vcsg_pkg::HPROD_W'(vcsg_pkg::HERALD_MUL);

    assign q_pop = !q_empty && (!out_valid_reg || !out_stall);

    // Time and space checks, formed without wrap
    assign hangover_done = {1'b0, q_head.tick}
                         > ({1'b0, last_noise_reg} + TW'(cfg.max_silent));
    assign delay_done    = {1'b0, q_head.tick}
                         >= ({1'b0, work_first} + TW'(cfg.post_delay));
    assign herald_fits   = (herald_len_reg != '0)
                         && ((HSUM_W'(q_head.len) + HSUM_W'(herald_len_reg)) <= HSUM_LIMIT);
    assign held          = (fill_reg < FILL_LIMIT) ? fill_reg : FILL_LIMIT;
    assign room          = FILL_LIMIT - held;

    // Decide the gate action for the buffer at the head of the queue
    always_comb
    begin
        phase_next       = phase_reg;
        last_noise_next  = last_noise_reg;
        first_noise_next = first_noise_reg;
        fill_next        = fill_reg;
        work_phase       = phase_reg;
        work_first       = first_noise_reg;
        action_next      = vcsg_pkg::ACT_DROP;
        herald_next      = '0;
        send_next        = '0;
        reported_next    = fill_reg;

        if (q_head.noisy)
            last_noise_next = q_head.tick;

        if (!q_head.noisy && hangover_done)
        begin
            // Close the gate and empty the store
            phase_next    = vcsg_pkg::PH_SILENCE;
            fill_next     = '0;
            reported_next = '0;
        end
        else
        begin
            // Open the gate on the first noisy buffer
            if (phase_reg == vcsg_pkg::PH_SILENCE && q_head.noisy)
            begin
                work_phase  = vcsg_pkg::PH_COLLECT;
                work_first  = q_head.tick;
                herald_next = herald_fits ? vcsg_pkg::LEN_W'(herald_len_reg) : '0;
            end
            phase_next       = work_phase;
            first_noise_next = work_first;

            if (work_phase != vcsg_pkg::PH_SILENCE)
            begin
                send_next = q_head.len + herald_next;
                if (work_phase == vcsg_pkg::PH_COLLECT)
                begin
                    if (!delay_done && ({1'b0, send_next} <= (vcsg_pkg::LEN_W + 1)'(room)))
                    begin
                        fill_next     = fill_reg + vcsg_pkg::FILL_W'(send_next);
                        action_next   = vcsg_pkg::ACT_STORE;
                        reported_next = fill_next;
                    end
                    else if (fill_reg != '0)
                    begin
                        action_next   = vcsg_pkg::ACT_SEND_STORE;
                        reported_next = fill_reg;
                        fill_next     = '0;
                        phase_next    = vcsg_pkg::PH_STREAM;
                    end
                    else
                    begin
                        action_next = vcsg_pkg::ACT_SEND_FIRST;
                        phase_next  = vcsg_pkg::PH_STREAM;
                    end
                end
                else
                begin
                    action_next = vcsg_pkg::ACT_SEND_CUR;
                end
            end
        end
    end

    // Gate state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= vcsg_pkg::PH_SILENCE;
            last_noise_reg  <= '0;
            first_noise_reg <= '0;
            fill_reg        <= '0;
            herald_len_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            herald_len_reg <= herald_prod[vcsg_pkg::HPROD_W-1:vcsg_pkg::HERALD_SHIFT];
            if (q_pop)
            begin
                phase_reg       <= phase_next;
                last_noise_reg  <= last_noise_next;
                first_noise_reg <= first_noise_next;
                fill_reg        <= fill_next;
                out_valid_reg   <= 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            action_reg   <= action_next;
            noisy_reg    <= q_head.noisy;
            herald_reg   <= herald_next;
            send_reg     <= send_next;
            reported_reg <= reported_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign action         = action_reg;
    assign noisy          = noisy_reg;
    assign herald_samples = herald_reg;
    assign send_length    = send_reg;
    assign buffered_bytes = reported_reg;

endmodule

### design/voice_capture_silence_gate.sv
// Top level of the voice capture silence gate: configuration registers, front,
// queue and back. Depends on vcsg_pkg, vcsg_front, vcsg_fifo and vcsg_back.
//
// Samples enter one per cycle; a result leaves for each sample that ends a
// capture buffer, passing the front's end-of-buffer stage, the queue and the
// back's output register. Input is held only when the four-entry queue
// between front and back is full, which happens only when results are
// stalled; otherwise one sample is taken every cycle, buffers of a single
// sample included. The noise test is one 9 x 12 bit multiply in the front's
// end stage, and the gate decisions are made in the cycle that moves an entry
// from the queue to the output register. Configuration is written through
// cfg_we/cfg_index/cfg_data; the user must do so only while no buffer is in
// flight; the block does not enforce this. Herald length has its own register.
module voice_capture_silence_gate #(
    parameter int STORE_LIMIT    = 11017,
    parameter int SUBSAMPLE_STEP = 16,
    parameter int READ_LIMIT     = 50000
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [vcsg_pkg::TICKS_W-1:0]      cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        sample,
    input  logic                              last_of_buffer,
    input  logic [vcsg_pkg::TIME_W-1:0]       tick,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [vcsg_pkg::ACT_W-1:0]        action,
    output logic                              noisy,
    output logic [vcsg_pkg::LEN_W-1:0]        herald_samples,
    output logic [vcsg_pkg::LEN_W-1:0]        send_length,
    output logic [vcsg_pkg::FILL_W-1:0]       buffered_bytes
);

    logic [vcsg_pkg::THR_W-1:0]     threshold_reg;
    vcsg_pkg::gate_cfg_t            cfg_reg;

    logic                           in_accept;
    logic                           hold_input;
    logic                           q_push;
    logic                           q_pop;
    logic                           q_full;
    logic                           q_empty;
    vcsg_pkg::buf_summary_t         q_in;
    vcsg_pkg::buf_summary_t         q_head;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            cfg_reg       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vcsg_pkg::REG_THRESHOLD:  threshold_reg <= cfg_data[vcsg_pkg::THR_W-1:0];
                vcsg_pkg::REG_MAX_SILENT: cfg_reg.max_silent <= cfg_data;
                vcsg_pkg::REG_POST_DELAY: cfg_reg.post_delay <= cfg_data;
                vcsg_pkg::REG_HERALD:
                    cfg_reg.herald_ticks <= cfg_data[vcsg_pkg::HTICKS_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_stall  = hold_input;
    assign in_accept = in_valid && !in_stall;

    vcsg_front #(
        .SUBSAMPLE_STEP (SUBSAMPLE_STEP),
        .READ_LIMIT     (READ_LIMIT)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_accept      (in_accept),
        .sample         (sample),
        .last_of_buffer (last_of_buffer),
        .tick           (tick),
        .threshold      (threshold_reg),
        .q_full         (q_full),
        .hold_input     (hold_input),
        .q_push         (q_push),
        .q_data         (q_in)
    );

    vcsg_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    vcsg_back #(
        .STORE_LIMIT (STORE_LIMIT),
        .READ_LIMIT  (READ_LIMIT)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_empty        (q_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .action         (action),
        .noisy          (noisy),
        .herald_samples (herald_samples),
        .send_length    (send_length),
        .buffered_bytes (buffered_bytes)
    );

    // Never write into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("queue written while full");

    // Store occupancy stays within its limit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (buffered_bytes <= vcsg_pkg::FILL_W'(STORE_LIMIT)))
        else $error("store occupancy above limit");

    // A herald only accompanies the buffer that opens the gate
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && herald_samples != '0) |->
        (noisy && (action == vcsg_pkg::ACT_STORE || action == vcsg_pkg::ACT_SEND_FIRST)))
        else $error("herald on a buffer that did not open the gate");

    // A dropped buffer carries no length
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && action == vcsg_pkg::ACT_DROP) |->
        (send_length == '0 && herald_samples == '0))
        else $error("dropped buffer with nonzero length");

endmodule

### test/silence_gate_checker.sv
// Scoreboard for the voice capture silence gate: predicts the decision for every
// capture buffer from the accepted samples and compares it with the result channel.
// Depends on vcsg_pkg for the gate phase enum, register indexes and action codes.
module silence_gate_checker #(
    parameter int STORE_LIMIT    = 11017,
    parameter int SUBSAMPLE_STEP = 16,
    parameter int READ_LIMIT     = 50000
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [vcsg_pkg::TICKS_W-1:0] cfg_data,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [7:0]                   sample,
    input  logic                         last_of_buffer,
    input  logic [vcsg_pkg::TIME_W-1:0]  tick,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [vcsg_pkg::ACT_W-1:0]   action,
    input  logic                         noisy,
    input  logic [vcsg_pkg::LEN_W-1:0]   herald_samples,
    input  logic [vcsg_pkg::LEN_W-1:0]   send_length,
    input  logic [vcsg_pkg::FILL_W-1:0]  buffered_bytes,
    output int                           mismatches,
    output int                           outstanding
);
    import vcsg_pkg::*;

    localparam int unsigned VOICE_RATE = 11025;
    localparam int unsigned TICK_RATE  = 60;
    localparam int unsigned MID        = 128;
    localparam int unsigned THR_CAP    = 256;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic              noisy;
        logic [LEN_W-1:0]  herald;
        logic [LEN_W-1:0]  send_len;
        logic [FILL_W-1:0] fill;
    } gate_result_t;

    // Register copies
    logic [THR_W-1:0]    thr_q8;
    logic [TICKS_W-1:0]  hangover_ticks;
    logic [TICKS_W-1:0]  hold_ticks;
    logic [HTICKS_W-1:0] herald_ticks;

    // Gate and buffer state
    gate_phase_t       gate_state;
    logic [TIME_W-1:0] last_noise_at;
    logic [TIME_W-1:0] first_noise_at;
    int unsigned       store_fill;
    int unsigned       dev_sum;
    int unsigned       taps;
    int unsigned       step_pos;
    int unsigned       buf_len;

    gate_result_t decisions_due[$];
    gate_result_t got;
    gate_result_t want;

    function automatic int unsigned herald_for(input int unsigned len);
        int unsigned h;
        h = (herald_ticks * VOICE_RATE) / TICK_RATE;
        if (h == 0 || len + h > READ_LIMIT)
            return 0;
        return h;
    endfunction

    function automatic int field_differs(input string field, input longint unsigned exp_v,
                                         input longint unsigned act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, field, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    // Accumulate one sample and, at the buffer end, work out the gate decision
    task automatic classify_sample(input logic [7:0] s, input logic eob,
                                   input logic [TIME_W-1:0] t);
        gate_result_t      r;
        int unsigned       thr;
        int unsigned       len;
        int unsigned       room;
        int unsigned       flushed;
        longint unsigned   limit_at;
        logic              loud;
        logic              settled;
        logic              flush;
        if (buf_len < READ_LIMIT)
        begin
            if (step_pos == 0)
            begin
                dev_sum += (s >= MID) ? s - MID : MID - s;
                taps++;
            end
            step_pos = (step_pos + 1 >= SUBSAMPLE_STEP) ? 0 : step_pos + 1;
            buf_len++;
        end
        if (eob)
        begin
            thr = (thr_q8 > THR_CAP) ? THR_CAP : thr_q8;
            loud = (taps != 0) && (2 * dev_sum > thr * taps);
            len = buf_len;
            dev_sum = 0;
            taps = 0;
            step_pos = 0;
            buf_len = 0;
            r = '0;
            r.noisy = loud;
            r.action = ACT_DROP;
            settled = 1'b0;
            flush = 1'b0;
            flushed = 0;

            // Refresh the noise time, or close the gate once the hangover has run out
            limit_at = last_noise_at;
            limit_at += hangover_ticks;
            if (loud)
                last_noise_at = t;
            else if (t > limit_at)
            begin
                gate_state = PH_SILENCE;
                store_fill = 0;
                settled = 1'b1;
            end

            // Open the gate on the first noisy buffer
            if (!settled && gate_state == PH_SILENCE)
            begin
                if (!loud)
                    settled = 1'b1;
                else
                begin
                    gate_state = PH_COLLECT;
                    first_noise_at = last_noise_at;
                    r.herald = LEN_W'(herald_for(len));
                end
            end

            if (!settled)
            begin
                r.send_len = LEN_W'(len + r.herald);
                if (gate_state == PH_COLLECT)
                begin
                    limit_at = first_noise_at;
                    limit_at += hold_ticks;
                    room = STORE_LIMIT - ((store_fill < STORE_LIMIT) ? store_fill : STORE_LIMIT);
                    if (t < limit_at && r.send_len <= room)
                    begin
                        store_fill += r.send_len;
                        r.action = ACT_STORE;
                    end
                    else if (store_fill != 0)
                    begin
                        r.action = ACT_SEND_STORE;
                        flush = 1'b1;
                        flushed = store_fill;
                        store_fill = 0;
                        gate_state = PH_STREAM;
                    end
                    else
                    begin
                        r.action = ACT_SEND_FIRST;
                        gate_state = PH_STREAM;
                    end
                end
                else
                    r.action = ACT_SEND_CUR;
            end
            r.fill = FILL_W'(flush ? flushed : store_fill);
            decisions_due.push_back(r);
        end
    endtask

    // Track register writes, predict on input transactions, compare on output ones
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_q8 = '0;
            hangover_ticks = '0;
            hold_ticks = '0;
            herald_ticks = '0;
            gate_state = PH_SILENCE;
            last_noise_at = '0;
            first_noise_at = '0;
            store_fill = 0;
            dev_sum = 0;
            taps = 0;
            step_pos = 0;
            buf_len = 0;
            decisions_due.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_THRESHOLD:  thr_q8 = cfg_data[THR_W-1:0];
                    REG_MAX_SILENT: hangover_ticks = cfg_data;
                    REG_POST_DELAY: hold_ticks = cfg_data;
                    REG_HERALD:     herald_ticks = cfg_data[HTICKS_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                classify_sample(sample, last_of_buffer, tick);
            if (out_valid && !out_stall)
            begin
                got = {action, noisy, herald_samples, send_length, buffered_bytes};
                if (decisions_due.size() == 0)
                begin
                    $display(
                        "%0t: unexpected result: action %0d noisy %0d herald %0d len %0d fill %0d",
                        $time, got.action, got.noisy, got.herald, got.send_len, got.fill);
                    mismatches++;
                end
                else
                begin
                    want = decisions_due.pop_front();
                    mismatches += field_differs("action", want.action, got.action)
                                + field_differs("noisy", want.noisy, got.noisy)
                                + field_differs("herald_samples", want.herald, got.herald)
                                + field_differs("send_length", want.send_len, got.send_len)
                                + field_differs("buffered_bytes", want.fill, got.fill);
                end
            end
            outstanding <= decisions_due.size();
        end
    end

endmodule

### test/testbench.sv
// Top of the silence gate testbench: clock, reset, sample stimulus, result stalls
// and the verdict. Depends on vcsg_pkg, voice_capture_silence_gate and silence_gate_checker.
module testbench;
    import vcsg_pkg::*;

    localparam int STORE_LIMIT     = 11017;
    localparam int SUBSAMPLE_STEP  = 16;
    localparam int READ_LIMIT      = 50000;
    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 8;
    localparam int ITEM_TARGET     = 1900;
    localparam int PHASES          = 12;
    localparam int SETTLE_CYCLES   = 6;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int BURST_BUFFERS   = 40;
    localparam int WATCHDOG_LIMIT  = 5000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [1:0]          cfg_index = '0;
    logic [TICKS_W-1:0]  cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [7:0]          sample = 8'd128;
    logic                last_of_buffer = 1'b0;
    logic [TIME_W-1:0]   tick = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [ACT_W-1:0]    action;
    logic                noisy;
    logic [LEN_W-1:0]    herald_samples;
    logic [LEN_W-1:0]    send_length;
    logic [FILL_W-1:0]   buffered_bytes;
    int                  mismatches;
    int                  outstanding;

    int                  items_sent = 0;
    int                  idle_cycles = 0;
    bit                  gapless = 1'b0;
    bit                  hold_off_req = 1'b0;
    bit                  hold_active = 1'b0;
    logic [TIME_W-1:0]   tick_now = '0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    voice_capture_silence_gate #(
        .STORE_LIMIT    (STORE_LIMIT),
        .SUBSAMPLE_STEP (SUBSAMPLE_STEP),
        .READ_LIMIT     (READ_LIMIT)
    ) i_dut (.*);

    silence_gate_checker #(
        .STORE_LIMIT    (STORE_LIMIT),
        .SUBSAMPLE_STEP (SUBSAMPLE_STEP),
        .READ_LIMIT     (READ_LIMIT)
    ) i_checker (.*);

    // Offer one sample and hold it until the transaction completes
    task automatic offer_sample(input logic [7:0] s, input logic eob,
                                input logic [TIME_W-1:0] t);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        gap = 0;
        if (!gapless && r >= 70)
            gap = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= s;
        last_of_buffer <= eob;
        tick <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Send a whole capture buffer with samples drawn from [lo, hi]
    task automatic send_buffer(input int len, input int lo, input int hi,
                               input logic [TIME_W-1:0] t_end);
        logic [7:0] s;
        for (int i = 0; i < len; i++)
        begin
            s = 8'($urandom_range(lo, hi));
            offer_sample(s, i == len - 1, (i == len - 1) ? t_end : $urandom);
        end
    endtask

    // Stop offering, let every decision arrive, then allow the pipeline to settle
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all four registers once the gate is idle
    task automatic program_gate(input logic [THR_W-1:0] thr, input logic [TICKS_W-1:0] hang,
                                input logic [TICKS_W-1:0] delay,
                                input logic [HTICKS_W-1:0] htk);
        logic [TICKS_W-1:0] pad;
        wait_for_results();
        pad = TICKS_W'($urandom);
        cfg_we <= 1'b1;
        cfg_index <= REG_THRESHOLD;
        cfg_data <= {pad[TICKS_W-1:THR_W], thr};
        @(posedge clk);
        cfg_index <= REG_MAX_SILENT;
        cfg_data <= hang;
        @(posedge clk);
        cfg_index <= REG_POST_DELAY;
        cfg_data <= delay;
        @(posedge clk);
        cfg_index <= REG_HERALD;
        cfg_data <= {pad[TICKS_W-1:HTICKS_W], htk};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Result side: random stall stretches, plus one long hold-off on request
    initial
    begin
        int r;
        wait (rst_n === 1'b1);
        forever
        begin
            r = $urandom_range(0, 99);
            if (hold_off_req)
            begin
                hold_active = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_active = 1'b0;
                hold_off_req = 1'b0;
            end
            else if (r < 45)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
            else if (r < 85)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(8, 40)) @(posedge clk);
            end
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Stimulus
    initial
    begin
        int r;
        int len;
        int spread;
        int phase_end;
        int random_base;
        logic [THR_W-1:0]    thr;
        logic [TICKS_W-1:0]  hang;
        logic [TICKS_W-1:0]  delay;
        logic [HTICKS_W-1:0] htk;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset registers: quiet drop, first send, streaming, hangover, gate closing
        send_buffer(1, 128, 128, 32'd0);
        send_buffer(1, 0, 0, 32'd5);
        send_buffer(3, 255, 255, 32'd5);
        send_buffer(2, 128, 128, 32'd5);
        send_buffer(1, 128, 128, 32'd6);

        // Threshold above full scale: never noisy
        program_gate(9'd511, 16'hFFFF, 16'hFFFF, 10'h3FF);
        send_buffer(17, 0, 255, 32'd100);

        // Large herald nearly fills the store, then the store overflows and flushes
        program_gate(9'd100, 16'hFFFF, 16'hFFFF, 10'd59);
        send_buffer(1, 0, 0, 32'd200);
        send_buffer(20, 0, 0, 32'd210);
        send_buffer(300, 255, 255, 32'd220);
        send_buffer(5, 128, 128, 32'd230);

        // Herald against the read limit and ticks at the top of the range
        program_gate(9'd100, 16'd10, 16'd0, 10'd272);
        send_buffer(1, 128, 128, 32'd100000);
        send_buffer(30, 0, 0, 32'd100001);
        send_buffer(1, 128, 128, 32'd200000);
        send_buffer(20, 0, 0, 32'd200001);
        send_buffer(1, 128, 128, 32'hFFFF_FFFF);
        send_buffer(1, 0, 0, 32'hFFFF_FFFF);
        send_buffer(1, 128, 128, 32'hFFFF_FFFF);

        // Random phases, each under its own register setting
        random_base = items_sent;
        tick_now = $urandom;
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
            begin
                thr = '0;
                hang = '0;
                delay = '0;
                htk = '0;
            end
            else if (p == 1)
            begin
                thr = 9'd256;
                hang = 16'hFFFF;
                delay = 16'hFFFF;
                htk = 10'h3FF;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    thr = '0;
                else if (r < 20)
                    thr = THR_W'($urandom_range(256, 511));
                else
                    thr = THR_W'($urandom_range(1, 255));
                r = $urandom_range(0, 99);
                hang = (r < 15) ? 16'd0 : (r < 30) ? 16'hFFFF : 16'($urandom_range(0, 300));
                r = $urandom_range(0, 99);
                delay = (r < 15) ? 16'd0 : (r < 30) ? 16'hFFFF : 16'($urandom_range(0, 300));
                r = $urandom_range(0, 99);
                if (r < 20)
                    htk = '0;
                else if (r < 30)
                    htk = 10'h3FF;
                else if (r < 45)
                    htk = HTICKS_W'($urandom_range(55, 60));
                else if (r < 55)
                    htk = HTICKS_W'($urandom_range(265, 272));
                else
                    htk = HTICKS_W'($urandom_range(0, 300));
            end
            program_gate(thr, hang, delay, htk);

            // Hold results back while single-sample buffers keep arriving
            if (p == 3)
            begin
                wait_for_results();
                hold_off_req = 1'b1;
                wait (hold_active);
                gapless = 1'b1;
                for (int b = 0; b < BURST_BUFFERS; b++)
                begin
                    tick_now += $urandom_range(0, 3);
                    send_buffer(1, 0, 255, tick_now);
                end
            end

            phase_end = random_base + ((p + 1) * (ITEM_TARGET - random_base)) / PHASES;
            while (items_sent < phase_end)
            begin
                // Occasionally pause until every decision has come back
                if ($urandom_range(0, 99) < 3)
                    wait_for_results();
                r = $urandom_range(0, 99);
                if (r < 70)
                    len = $urandom_range(1, 16);
                else if (r < 95)
                    len = $urandom_range(17, 64);
                else
                    len = $urandom_range(65, 300);
                r = $urandom_range(0, 99);
                if (r < 70)
                    tick_now += $urandom_range(0, 20);
                else if (r < 92)
                    tick_now += $urandom_range(0, 300);
                else if (r < 97)
                    tick_now += $urandom_range(0, 70000);
                else
                    tick_now = $urandom;
                spread = $urandom_range(0, 128);
                gapless = ($urandom_range(0, 9) < 3);
                send_buffer(len, 128 - spread, (spread == 128) ? 255 : 128 + spread, tick_now);
            end
            gapless = 1'b0;
        end

        wait_for_results();
        if (mismatches == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
